### sv/bbcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbcs_pkg
// Shared types and constants of the bounding box center and scale unit.
// ----------------------------------------------------------------------------
package bbcs_pkg;

   // Coordinate width (signed Q8.8) and scale width (unsigned Q8.8)
   localparam int COORD_BITS = 16;
   localparam int SCALE_BITS = 16;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(256);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // One vertex: element 0 is x, 1 is y, 2 is z
   typedef coord_type [2:0] vertex_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic signed [COORD_BITS-1:0] z_coord;
      logic                         is_final;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
      logic                         end_of_run;
   } rsp_word_type;

   // Finished mesh handed from the front to the back
   typedef struct packed {
      logic       bank;
      vertex_type lo;
      vertex_type hi;
   } job_type;

endpackage
`default_nettype wire

### sv/bounding_box_center_and_scale_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Vertices are taken one per cycle while fewer than two meshes wait in the back.
// Each emitted vertex passes through store read, center, multiply, divider
// load, 16 restoring divide steps and emit; a mesh first sets up its extent.
// The back's serial divider sets the output rate; the two store banks let the
// next mesh load while the previous one is emitted.
// Reset (synchronous, active high) empties the queues and sets the scale to 1.0.
// ----------------------------------------------------------------------------
// bounding_box_center_and_scale_unit
// Normalizes a mesh to a unit cube about its bounding box center, then scales.
// ----------------------------------------------------------------------------
module bounding_box_center_and_scale_unit #(
   parameter int MAX_VERTS = 64
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            push,
   input  bbcs_pkg::req_word_type         req_word,
   output logic                           full,
   output logic                           empty,
   input  wire                            pop,
   output bbcs_pkg::rsp_word_type         rsp_word,
   input  wire                            csr_wr_en,
   input  wire [bbcs_pkg::SCALE_BITS-1:0] csr_wr_data
);

   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
   localparam int QW = $bits(bbcs_pkg::job_type) + CW;

   logic                 q_full;
   logic                 mem_wr_en;
   logic [AW:0]          mem_wr_addr;
   bbcs_pkg::vertex_type mem_wr_data;
   logic                 job_push;
   bbcs_pkg::job_type    job_in;
   logic [CW-1:0]        job_in_count;
   logic                 job_valid;
   logic                 job_pop;
   logic [QW-1:0]        job_head;
   bbcs_pkg::job_type    job_out;
   logic [CW-1:0]        job_out_count;

   // Front: accept and box tracking
   bbcs_front #(.MAX_VERTS(MAX_VERTS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_word    (req_word),
      .full        (full),
      .q_full      (q_full),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .job_push    (job_push),
      .job_data    (job_in),
      .job_count   (job_in_count)
   );

   // Queue of finished meshes
   bbcs_job_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_in, job_in_count}),
      .pop       (job_pop),
      .valid     (job_valid),
      .full      (q_full),
      .head      (job_head)
   );

   assign job_out       = job_head[QW-1:CW];
   assign job_out_count = job_head[CW-1:0];

   // Back: normalize and emit
   bbcs_back #(.MAX_VERTS(MAX_VERTS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .job_valid   (job_valid),
      .job_data    (job_out),
      .job_count   (job_out_count),
      .job_pop     (job_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_word    (rsp_word)
   );

endmodule
`default_nettype wire

### sv/bbcs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbcs_front
// Accepts vertices, writes them into the current store bank, tracks the
// bounding box and posts a job when the final vertex arrives.
// ----------------------------------------------------------------------------
module bbcs_front #(
   parameter int MAX_VERTS = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  bbcs_pkg::req_word_type       req_word,
   output logic                         full,
   input  wire                          q_full,
   output logic                         mem_wr_en,
   output logic [((MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1):0] mem_wr_addr,
   output bbcs_pkg::vertex_type         mem_wr_data,
   output logic                         job_push,
   output bbcs_pkg::job_type            job_data,
   output logic [$clog2(MAX_VERTS + 1)-1:0] job_count
);

   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;

   logic                 bank_ff, bank_in;
   logic [CW-1:0]        count_ff, count_in;
   bbcs_pkg::vertex_type lo_ff, lo_in;
   bbcs_pkg::vertex_type hi_ff, hi_in;
   bbcs_pkg::vertex_type vin;
   logic                 accept;
   logic                 store;
   logic [CW-1:0]        count_nx;

   // Accept and box update
   always_comb begin
      vin[0] = req_word.x_coord;
      vin[1] = req_word.y_coord;
      vin[2] = req_word.z_coord;
      accept = push && !q_full;
      store  = count_ff < CW'(MAX_VERTS);
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      if (store) begin
         for (int a = 0; a < 3; a++) begin
            if (count_ff == '0 || $signed(vin[a]) < $signed(lo_ff[a])) begin
               lo_in[a] = vin[a];
            end
            if (count_ff == '0 || $signed(vin[a]) > $signed(hi_ff[a])) begin
               hi_in[a] = vin[a];
            end
         end
      end
      count_nx = store ? count_ff + CW'(1) : count_ff;
      count_in = count_ff;
      bank_in  = bank_ff;
      if (accept) begin
         if (req_word.is_final) begin
            count_in = '0;
            bank_in  = !bank_ff;
         end else begin
            count_in = count_nx;
         end
      end
   end

   // Store write and job post
   always_comb begin
      full          = q_full;
      mem_wr_en     = accept && store;
      mem_wr_addr   = {bank_ff, count_ff[AW-1:0]};
      mem_wr_data   = vin;
      job_push      = accept && req_word.is_final;
      job_data.bank = bank_ff;
      job_data.lo   = lo_in;
      job_data.hi   = hi_in;
      job_count     = count_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         bank_ff  <= bank_in;
         count_ff <= count_in;
      end
   end

   // Box corners need no reset: the first vertex of a mesh loads them
   always_ff @(posedge clock) begin
      if (accept) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

endmodule
`default_nettype wire

### sv/bbcs_job_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbcs_job_queue
// Two-entry queue of finished meshes between front and back. An entry is
// released only when the back has emitted the whole mesh, so the count also
// tells how many store banks are held.
// ----------------------------------------------------------------------------
module bbcs_job_queue #(
   parameter int WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  push_data,
   input  wire              pop,
   output logic             valid,
   output logic             full,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      valid  = cnt_ff != 2'd0;
      full   = cnt_ff == 2'd2;
      head   = slot_ff[rd_ptr_ff];
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### sv/bbcs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbcs_back
// Holds the two-bank vertex store, takes finished meshes from the job queue
// and emits every stored vertex as (p - center) * scale / extent with round
// to nearest and saturation. Three lanes share one restoring divider schedule.
// ----------------------------------------------------------------------------
module bbcs_back #(
   parameter int MAX_VERTS = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_wr_en,
   input  wire [bbcs_pkg::SCALE_BITS-1:0] csr_wr_data,
   input  wire                          mem_wr_en,
   input  wire [((MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1):0] mem_wr_addr,
   input  bbcs_pkg::vertex_type         mem_wr_data,
   input  wire                          job_valid,
   input  bbcs_pkg::job_type            job_data,
   input  wire [$clog2(MAX_VERTS + 1)-1:0] job_count,
   output logic                         job_pop,
   output logic                         empty,
   input  wire                          pop,
   output bbcs_pkg::rsp_word_type       rsp_word
);

   localparam int CW  = $clog2(MAX_VERTS + 1);
   localparam int AW  = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
   localparam int W   = bbcs_pkg::COORD_BITS;
   localparam int SW  = bbcs_pkg::SCALE_BITS;
   localparam int QB  = SW;
   localparam int PW  = W + SW;
   localparam int SBW = $clog2(QB);
   localparam int RW  = ((W > QB) ? W : QB) + 1;
   localparam logic [RW-1:0] CSIGN   = RW'(1) << (W - 1);
   localparam logic [W-1:0]  OUT_MAX = W'(CSIGN - RW'(1));

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SPAN   = 4'd1;
   localparam logic [3:0] ST_EXTENT = 4'd2;
   localparam logic [3:0] ST_READ   = 4'd3;
   localparam logic [3:0] ST_PREP   = 4'd4;
   localparam logic [3:0] ST_MUL    = 4'd5;
   localparam logic [3:0] ST_LOAD   = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_EMIT   = 4'd8;

   // Bank bit on top of the vertex index
   bbcs_pkg::vertex_type mem [2**(AW+1)];

   logic [3:0]             state_ff, state_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [SBW-1:0]         step_ff, step_in;
   logic [SW-1:0]          scale_ff;
   logic [W-1:0]           span_ff [3];
   logic signed [W:0]      sum_ff [3];
   logic [W-1:0]           ext_ff;
   bbcs_pkg::vertex_type   rd_data_ff;
   logic [2:0]             neg_ff;
   logic [W-1:0]           dmag_ff [3];
   logic [PW-1:0]          prod_ff [3];
   logic [W:0]             rem_ff [3], rem_in [3];
   logic [QB-1:0]          quo_ff [3], quo_in [3];
   logic [W:0]             rem_ld [3];
   logic [QB-1:0]          quo_ld [3];
   bbcs_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff;
   logic                   slot_free;
   logic                   last;
   logic [W-1:0]           ext_in;
   logic [W-1:0]           res [3];

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= bbcs_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // Vertex store, two banks, registered read
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= mem[{job_data.bank, idx_ff}];
      end
   end

   // Sequencer
   always_comb begin
      slot_free = !rsp_valid_ff || pop;
      last      = (CW'(idx_ff) + CW'(1)) == job_count;
      state_in  = state_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      job_pop   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (job_valid) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN:   state_in = ST_EXTENT;
         ST_EXTENT: state_in = ST_READ;
         ST_READ:   state_in = ST_PREP;
         ST_PREP:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_LOAD;
         ST_LOAD: begin
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            step_in = step_ff + SBW'(1);
            if (step_ff == SBW'(QB - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               if (last) begin
                  job_pop  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff  <= idx_in;
      step_ff <= step_in;
   end

   // Largest extent over the three axes
   always_comb begin
      ext_in = span_ff[0];
      if (span_ff[1] > ext_in) begin
         ext_in = span_ff[1];
      end
      if (span_ff[2] > ext_in) begin
         ext_in = span_ff[2];
      end
   end

   // Divider load and step for each lane; divisor is twice the extent
   always_comb begin
      logic [PW:0]  dvd;
      logic [W+1:0] trial;
      logic [W+1:0] dsor;
      logic         ge;
      dsor = {1'b0, ext_ff, 1'b0};
      for (int a = 0; a < 3; a++) begin
         dvd       = {1'b0, prod_ff[a]} + (PW+1)'(ext_ff);
         rem_ld[a] = {1'b0, dvd[PW-1:QB]};
         quo_ld[a] = dvd[QB-1:0];
         trial     = {rem_ff[a], quo_ff[a][QB-1]};
         ge        = trial >= dsor;
         rem_in[a] = ge ? (W+1)'(trial - dsor) : trial[W:0];
         quo_in[a] = {quo_ff[a][QB-2:0], ge};
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      logic signed [W+1:0] d;
      for (int a = 0; a < 3; a++) begin
         if (state_ff == ST_SPAN) begin
            span_ff[a] <= W'($signed({job_data.hi[a][W-1], job_data.hi[a]})
                              - $signed({job_data.lo[a][W-1], job_data.lo[a]}));
            sum_ff[a]  <= $signed({job_data.hi[a][W-1], job_data.hi[a]})
                          + $signed({job_data.lo[a][W-1], job_data.lo[a]});
         end
         if (state_ff == ST_PREP) begin
            d = $signed({rd_data_ff[a][W-1], rd_data_ff[a], 1'b0})
                - $signed({sum_ff[a][W], sum_ff[a]});
            neg_ff[a]  <= d[W+1];
            dmag_ff[a] <= d[W+1] ? W'(-d) : d[W-1:0];
         end
         if (state_ff == ST_MUL) begin
            prod_ff[a] <= PW'(dmag_ff[a]) * PW'(scale_ff);
         end
         if (state_ff == ST_LOAD) begin
            rem_ff[a] <= rem_ld[a];
            quo_ff[a] <= quo_ld[a];
         end else if (state_ff == ST_DIV) begin
            rem_ff[a] <= rem_in[a];
            quo_ff[a] <= quo_in[a];
         end
      end
      if (state_ff == ST_EXTENT) begin
         ext_ff <= ext_in;
      end
   end

   // Sign, saturation and zero-extent bypass
   always_comb begin
      logic [RW-1:0] qc;
      logic [RW-1:0] nv;
      for (int a = 0; a < 3; a++) begin
         qc = (RW'(quo_ff[a]) > CSIGN) ? CSIGN : RW'(quo_ff[a]);
         nv = RW'(0) - qc;
         if (ext_ff == '0) begin
            res[a] = rd_data_ff[a];
         end else if (neg_ff[a]) begin
            res[a] = nv[W-1:0];
         end else if (qc == CSIGN) begin
            res[a] = OUT_MAX;
         end else begin
            res[a] = qc[W-1:0];
         end
      end
      rsp_in.out_x      = res[0];
      rsp_in.out_y      = res[1];
      rsp_in.out_z      = res[2];
      rsp_in.end_of_run = last;
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_EMIT && slot_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule
`default_nettype wire
